[hw/rtl/u8u16_pkg.sv]
// Package for the UTF-8 to UTF-16 (BMP) decoder.
// Holds the decoder state and result types, result kind codes and offset table.
// No dependencies.
package u8u16_pkg;

  localparam int SumWidth  = 20;
  localparam int UnitWidth = 16;

  localparam logic [1:0] KIND_UNIT  = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [7:0] LEAD1_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;

  typedef struct packed {
    logic [1:0]          bytes_remaining;
    logic [1:0]          sequence_length;
    logic [SumWidth-1:0] accumulated_sum;
    logic                dropping_rest;
  } dec_state_t;

  typedef struct packed {
    logic                 has_result;
    logic [UnitWidth-1:0] code_unit;
    logic [1:0]           result_kind;
    logic                 end_of_string;
  } dec_result_t;

  // offset removed from the summed bytes, by continuation count
  function automatic logic [SumWidth-1:0] len_offset(input logic [1:0] seq_len);
    logic [SumWidth-1:0] off;
    case (seq_len)
      2'd1:    off = 20'h03080;
      2'd2:    off = 20'hE2080;
      default: off = '0;
    endcase
    return off;
  endfunction

endpackage

[hw/rtl/u8u16_step.sv]
// Next-state and result logic for one byte of the UTF-8 decoder.
// Purely combinational; uses u8u16_pkg.
module u8u16_step
  import u8u16_pkg::*;
(
  input  dec_state_t  cur,
  input  logic [7:0]  in_byte,
  input  logic        last_byte,
  output dec_state_t  nxt,
  output dec_result_t res
);

  logic [1:0]          trail;
  logic                bad_lead;
  logic [SumWidth-1:0] sum_shift;
  logic [SumWidth-1:0] unit_diff;
  logic [1:0]          rem_dec;

  always_comb begin
    trail    = 2'd0;
    bad_lead = 1'b0;
    if ((in_byte & LEAD1_MASK) == 8'h00) begin
      trail = 2'd0;
    end else if ((in_byte & LEAD2_MASK) == LEAD2_CODE) begin
      trail = 2'd1;
    end else if ((in_byte & LEAD3_MASK) == LEAD3_CODE) begin
      trail = 2'd2;
    end else begin
      bad_lead = 1'b1;
    end
  end

  assign sum_shift = {cur.accumulated_sum[SumWidth-7:0], 6'b0} + {12'b0, in_byte};
  assign unit_diff = sum_shift - len_offset(cur.sequence_length);
  assign rem_dec   = cur.bytes_remaining - 2'd1;

  always_comb begin
    nxt = cur;
    res = '{has_result: 1'b0, code_unit: '0, result_kind: KIND_UNIT, end_of_string: 1'b0};
    if (cur.dropping_rest) begin
      if (last_byte) begin
        nxt.dropping_rest = 1'b0;
        res.has_result    = 1'b1;
        res.result_kind   = KIND_END;
        res.end_of_string = 1'b1;
      end
    end else if (cur.bytes_remaining == 2'd0) begin
      if (bad_lead) begin
        nxt.bytes_remaining = '0;
        nxt.sequence_length = '0;
        nxt.accumulated_sum = '0;
        nxt.dropping_rest   = !last_byte;
        res.has_result      = 1'b1;
        res.result_kind     = KIND_ERROR;
        res.end_of_string   = last_byte;
      end else if (trail == 2'd0) begin
        res.has_result    = 1'b1;
        res.code_unit     = {8'h00, in_byte};
        res.end_of_string = last_byte;
      end else if (last_byte) begin
        nxt.bytes_remaining = '0;
        nxt.sequence_length = '0;
        nxt.accumulated_sum = '0;
        res.has_result      = 1'b1;
        res.result_kind     = KIND_ERROR;
        res.end_of_string   = 1'b1;
      end else begin
        nxt.accumulated_sum = {12'b0, in_byte};
        nxt.bytes_remaining = trail;
        nxt.sequence_length = trail;
      end
    end else begin
      if (rem_dec == 2'd0) begin
        nxt.bytes_remaining = '0;
        nxt.sequence_length = '0;
        nxt.accumulated_sum = '0;
        res.has_result      = 1'b1;
        res.code_unit       = unit_diff[UnitWidth-1:0];
        res.end_of_string   = last_byte;
      end else if (last_byte) begin
        nxt.bytes_remaining = '0;
        nxt.sequence_length = '0;
        nxt.accumulated_sum = '0;
        res.has_result      = 1'b1;
        res.result_kind     = KIND_ERROR;
        res.end_of_string   = 1'b1;
      end else begin
        nxt.accumulated_sum = sum_shift;
        nxt.bytes_remaining = rem_dec;
      end
    end
  end

endmodule

[hw/rtl/utf8_to_utf16_bmp_decoder_core.sv]
// Channel  | handshake           | payload
// in       | in_valid / in_stall   | in_byte[7:0], last_byte
// out      | out_valid / out_stall | code_unit[15:0], result_kind[1:0], end_of_string
//
// One byte per cycle while out_stall is low; input register, then result register.
// The decode step (u8u16_step) sits between the two registers and updates the sequence state.
// rst (synchronous, active high) clears valids and decoder state.
// A stalled result holds; the input register still drains bytes that give no result.
// Top level of the UTF-8 to UTF-16 BMP decoder; uses u8u16_pkg and u8u16_step.
module utf8_to_utf16_bmp_decoder_core
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_unit,
  output logic [1:0]  result_kind,
  output logic        end_of_string
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  dec_state_t  state;
  dec_state_t  state_next;
  dec_result_t res;
  logic        out_free;
  logic        s1_adv;
  logic        in_take;

  u8u16_step u_step (
    .cur      (state),
    .in_byte  (s1_byte),
    .last_byte(s1_last),
    .nxt      (state_next),
    .res      (res)
  );

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && (!res.has_result || out_free);
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= in_byte;
      s1_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_adv) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && res.has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.has_result) begin
      code_unit     <= res.code_unit;
      result_kind   <= res.result_kind;
      end_of_string <= res.end_of_string;
    end
  end

`ifndef SYNTHESIS
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_END |-> end_of_string)
    else $error("end-only transaction without end_of_string");

  a_no_unit_on_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_ERROR || result_kind == KIND_END) |-> code_unit == '0)
    else $error("error or end transaction carries a code unit");

  a_drop_no_seq: assert property (@(posedge clk) disable iff (rst)
    state.dropping_rest |-> state.bytes_remaining == 2'd0)
    else $error("dropping while a sequence is open");

  a_result_from_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result without a byte in the input register");
`endif

endmodule
